// ===== hdl/multi_led_blink_sequencer_unit_macros.svh =====
// assertion macros for the led blink sequencer checker
// no dependencies; taken in by the checker file
`ifndef MULTI_LED_BLINK_SEQUENCER_UNIT_MACROS_SVH
`define MULTI_LED_BLINK_SEQUENCER_UNIT_MACROS_SVH

// implication checked outside reset
`define MLBS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlbs assertion failed");

// next-cycle implication, checked during reset as well
`define MLBS_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mlbs assertion failed");

`endif

// ===== hdl/mlbs_pkg.sv =====
// shared types and constants for the led blink sequencer
// no dependencies; used by the top level and its checker
package mlbs_pkg;

   localparam int CHANNELS  = 4;
   localparam int CHAN_W    = 2;
   localparam int TIME_W    = 16;
   localparam int COUNT_W   = 8;
   localparam int LED_W     = 4;
   localparam int KIND_W    = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 2'd0,
      KIND_PROGRAM = 2'd1,
      KIND_SET     = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [COUNT_W-1:0] count_type;

endpackage

// ===== hdl/multi_led_blink_sequencer_unit.sv =====
// led blink sequencer top level: input register, state update, result register
// depends on mlbs_pkg
//
// req channel: one beat is one command; req_tuser carries the kind (tick,
// program channel, set level, release hold), req_tdata the command fields.
// rsp channel: exactly one beat per req beat, in order, giving the led levels,
// the active mask, the blink event flag and the hold flag after the command.
// a req beat accepted into the input register passes the state-update stage
// into the result register and is shown on rsp. throughput: one beat per cycle
// while rsp is not stalled, set by the single state-update stage between the
// input and result registers; all channels are updated in parallel in that stage.
// when rsp stalls, the result register holds and the input register keeps one
// more beat; req_tready drops only when both are full.
// reset clears all channel timing, counters, levels, hold and event state and
// empties both registers.
module multi_led_blink_sequencer_unit
   import mlbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // channel[1:0], on_duration[17:2], off_duration[33:18], blink_count[41:34],
   // continuous[42], hold_request[43], level_value[44], zero[47:45]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // led_levels[3:0], active_mask[7:4], blink_event[8], hold_active[9], zero[15:10]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // input register
   logic                  in_valid_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   kind_type              in_kind_ff;

   // channel state
   time_type              on_ff    [CHANNELS];
   time_type              off_ff   [CHANNELS];
   count_type             count_ff [CHANNELS];
   logic [CHANNELS-1:0]   cont_ff;
   time_type              tick_ff  [CHANNELS];
   logic [CHANNELS-1:0]   phase_ff;
   logic [CHANNELS-1:0]   level_ff;
   logic                  hold_ff;
   logic                  event_ff;

   time_type              on_in    [CHANNELS];
   time_type              off_in   [CHANNELS];
   count_type             count_in [CHANNELS];
   logic [CHANNELS-1:0]   cont_in;
   time_type              tick_in  [CHANNELS];
   logic [CHANNELS-1:0]   phase_in;
   logic [CHANNELS-1:0]   level_in;
   logic                  hold_in;
   logic                  event_in;

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic                  out_free;
   logic                  advance;
   logic [CHANNELS-1:0]   still;
   logic [LED_W-1:0]      led_bits;
   logic [LED_W-1:0]      act_bits;

   // command fields
   logic [CHAN_W-1:0]     f_channel;
   time_type              f_on;
   time_type              f_off;
   count_type             f_count;
   logic                  f_cont;
   logic                  f_hold;
   logic                  f_level;

   assign f_channel = in_data_ff[1:0];
   assign f_on      = in_data_ff[17:2];
   assign f_off     = in_data_ff[33:18];
   assign f_count   = in_data_ff[41:34];
   assign f_cont    = in_data_ff[42];
   assign f_hold    = in_data_ff[43];
   assign f_level   = in_data_ff[44];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      on_in    = on_ff;
      off_in   = off_ff;
      count_in = count_ff;
      cont_in  = cont_ff;
      tick_in  = tick_ff;
      phase_in = phase_ff;
      level_in = level_ff;
      hold_in  = hold_ff;
      event_in = event_ff;
      still    = '0;
      case (in_kind_ff)
         KIND_TICK: begin
            if (!hold_ff) begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (count_ff[c] != '0 || cont_ff[c]) begin
                     still[c]   = 1'b1;
                     tick_in[c] = tick_ff[c] + 1'b1;
                     if (tick_ff[c] > (phase_ff[c] ? on_ff[c] : off_ff[c])
                         && count_ff[c] != '0) begin
                        if (!cont_ff[c]) begin
                           count_in[c] = count_ff[c] - 1'b1;
                        end
                        if (count_in[c] == '0) begin
                           still[c] = 1'b0;
                        end
                        tick_in[c]  = '0;
                        phase_in[c] = !phase_ff[c];
                        level_in[c] = !phase_ff[c];
                     end
                  end
               end
               if (still == '0) begin
                  event_in = 1'b0;
               end
            end
         end
         KIND_PROGRAM: begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (int'(f_channel) == c) begin
                  event_in    = (f_count != '0) || f_cont;
                  on_in[c]    = f_on;
                  off_in[c]   = f_off;
                  count_in[c] = f_count;
                  cont_in[c]  = f_cont;
                  phase_in[c] = level_ff[c];
                  tick_in[c]  = '0;
                  if (f_hold) begin
                     hold_in = 1'b1;
                  end
               end
            end
         end
         KIND_SET: begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (int'(f_channel) == c) begin
                  level_in[c] = f_level;
               end
            end
         end
         KIND_RELEASE: begin
            hold_in = 1'b0;
         end
         default: begin
            hold_in = hold_ff;
         end
      endcase

      led_bits = '0;
      act_bits = '0;
      for (int c = 0; c < CHANNELS && c < LED_W; c++) begin
         led_bits[c] = level_in[c];
         act_bits[c] = (count_in[c] != '0) || cont_in[c];
      end
      rsp_data_in = {6'd0, hold_in, event_in, act_bits, led_bits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cont_ff      <= '0;
         phase_ff     <= '0;
         level_ff     <= '0;
         hold_ff      <= 1'b0;
         event_ff     <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            on_ff[c]    <= '0;
            off_ff[c]   <= '0;
            count_ff[c] <= '0;
            tick_ff[c]  <= '0;
         end
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
            in_data_ff  <= req_tdata;
            in_kind_ff  <= kind_type'(req_tuser);
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_data_in;
            on_ff        <= on_in;
            off_ff       <= off_in;
            count_ff     <= count_in;
            cont_ff      <= cont_in;
            tick_ff      <= tick_in;
            phase_ff     <= phase_in;
            level_ff     <= level_in;
            hold_ff      <= hold_in;
            event_ff     <= event_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== hdl/mlbs_checker.sv =====
// port-level checker for the led blink sequencer, bound to the top level
// depends on mlbs_pkg and multi_led_blink_sequencer_unit_macros.svh
`include "multi_led_blink_sequencer_unit_macros.svh"

module mlbs_checker
   import mlbs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic rsp_stall;
   logic req_beat;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_beat  = req_tvalid && req_tready;

   // nothing comes out right after reset
   `MLBS_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)

   // a stalled result beat keeps its data
   `MLBS_ASSERT_IMPLIES(a_rsp_hold, clock, reset, $past(rsp_stall) && !$past(reset),
      $stable(rsp_tdata))

   // back-pressure on req only when a result is waiting
   `MLBS_ASSERT_IMPLIES(a_ready_backpressure, clock, reset, !req_tready, rsp_tvalid)

   // a pending blink event always has a channel still active
   `MLBS_ASSERT_IMPLIES(a_event_active, clock, reset, rsp_tvalid && rsp_tdata[8],
      rsp_tdata[7:4] != 4'd0)

   // a command beat taken while no result waits shows on rsp after passing the input and result registers
   `MLBS_ASSERT_IMPLIES(a_beat_out, clock, reset, req_beat && !rsp_tvalid, ##2 rsp_tvalid)

endmodule

bind multi_led_blink_sequencer_unit mlbs_checker u_mlbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
